[hw/rtl/ppwc_pkg.sv]
// shared constants and controller/datapath command and status types
// for the path polygon wall crossing block; depends on nothing
package ppwc_pkg;

	localparam int CoordWidth = 32;
	localparam int DiffWidth  = CoordWidth + 1;
	localparam int ProdWidth  = 2 * DiffWidth;

	// eight products per edge: four orientations, two products each
	localparam int StepCount = 8;
	localparam int StepWidth = $clog2(StepCount);
	// the count runs on past the last step so the operand and product registers drain
	localparam int LastStep  = StepCount + 2;
	localparam int CntWidth  = $clog2(LastStep + 1);

	// orientation codes: which of the four sign tests a step belongs to
	localparam logic [1:0] ORI_MOVE_EDGE_START = 2'd0;
	localparam logic [1:0] ORI_MOVE_EDGE_END   = 2'd1;
	localparam logic [1:0] ORI_EDGE_MOVE_START = 2'd2;
	localparam logic [1:0] ORI_EDGE_MOVE_END   = 2'd3;

	typedef struct packed {
		logic                 load;
		logic                 issue;
		logic [StepWidth-1:0] step;
		logic                 close;
		logic                 eval;
		logic                 commit;
		logic                 emit;
	} ppwc_cmd_t;

	typedef struct packed {
		logic need_reg;
		logic need_close;
		logic is_last;
		logic out_busy;
	} ppwc_sts_t;

endpackage

[hw/rtl/path_polygon_wall_crossing.sv]
// top level of the path polygon wall crossing block
// depends on ppwc_pkg, ppwc_ctrl and ppwc_dp
//
// polygon vertices arrive one item at a time, each carrying the movement segment and a solid
// flag for the edge that starts at that vertex; first_vertex opens a polygon, last_vertex closes
// it and produces exactly one crossed result (touching counts as crossing). the edge into the
// current vertex is tested when the previous vertex was solid and the item is not a first
// vertex; on a last vertex the closing edge back to the first vertex is tested when the current
// vertex is solid. each tested edge uses the single shared 33 x 33 bit multiplier, which forms
// the eight cross products of an edge one per cycle, then drains its operand and product
// registers and combines the signs. an item passes through setup, its edge tests if any and
// a finish step, plus an emit step when it emits a result. vertex_stall is high from the cycle
// after acceptance until the item is finished; a result waiting under result_stall only holds
// the block when the next result is due
module path_polygon_wall_crossing import ppwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vertex_valid,
	output logic               vertex_stall,
	input  logic signed [31:0] move_start_x,
	input  logic signed [31:0] move_start_y,
	input  logic signed [31:0] move_end_x,
	input  logic signed [31:0] move_end_y,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic               wall_solid,
	input  logic               first_vertex,
	input  logic               last_vertex,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               crossed
);

	ppwc_cmd_t cmd;
	ppwc_sts_t sts;

	// sequencer: accepts items and steps the edge tests
	ppwc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: vertex registers, multiplier, sign tests and result register
	ppwc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.move_start_x (move_start_x),
		.move_start_y (move_start_y),
		.move_end_x   (move_end_x),
		.move_end_y   (move_end_y),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.wall_solid   (wall_solid),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.crossed      (crossed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	// a result is never pushed over one still waiting to be taken
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("result emitted while output register still held");

	// an accepted item always raises vertex_stall in the cycle after it is taken
	a_load_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> vertex_stall)
		else $error("block not busy after taking an item");

	// result_valid only rises from an emit command
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.emit))
		else $error("result appeared without an emit");

	// no multiplier step is issued while items are being taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!vertex_stall |-> !cmd.issue && !cmd.eval)
		else $error("edge test running while idle");

endmodule

[hw/rtl/ppwc_ctrl.sv]
// sequencer for the wall crossing test: takes items, runs edge tests, emits
// depends on ppwc_pkg
module ppwc_ctrl import ppwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vertex_valid,
	output logic      vertex_stall,
	input  ppwc_sts_t sts,
	output ppwc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_EDGE   = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]          state_q, state_n;
	logic [CntWidth-1:0] cnt_q, cnt_n;
	logic                close_q, close_n;

	assign vertex_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		cnt_n   = cnt_q;
		close_n = close_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = vertex_valid;
				if (vertex_valid) begin
					state_n = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cnt_n = '0;
				if (sts.need_reg) begin
					close_n = 1'b0;
					state_n = ST_EDGE;
				end else if (sts.need_close) begin
					close_n = 1'b1;
					state_n = ST_EDGE;
				end else begin
					state_n = ST_FINISH;
				end
			end
			ST_EDGE: begin
				cmd.issue = (cnt_q < CntWidth'(StepCount));
				cmd.step  = cnt_q[StepWidth-1:0];
				cmd.close = close_q;
				cnt_n     = cnt_q + 1'b1;
				if (cnt_q == CntWidth'(LastStep)) begin
					cmd.eval = 1'b1;
					cnt_n    = '0;
					if (!close_q && sts.need_close) begin
						close_n = 1'b1;
					end else begin
						state_n = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				cmd.commit = 1'b1;
				state_n    = sts.is_last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			close_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			close_q <= close_n;
		end
	end

endmodule

[hw/rtl/ppwc_dp.sv]
// datapath: item and polygon registers, shared multiplier, sign tests, result
// depends on ppwc_pkg
module ppwc_dp import ppwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] move_start_x,
	input  logic signed [31:0] move_start_y,
	input  logic signed [31:0] move_end_x,
	input  logic signed [31:0] move_end_y,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic               wall_solid,
	input  logic               first_vertex,
	input  logic               last_vertex,
	output logic               crossed,
	output logic               result_valid,
	input  logic               result_stall,
	input  ppwc_cmd_t          cmd,
	output ppwc_sts_t          sts
);

	localparam int Msb = CoordWidth - 1;

	logic signed [Msb:0] ms_x_q, ms_y_q, me_x_q, me_y_q, v_x_q, v_y_q;
	logic                solid_q, first_q, last_q;
	logic signed [Msb:0] first_vx_q, first_vy_q, prev_vx_q, prev_vy_q;
	logic                prev_solid_q, hit_q;

	logic signed [Msb:0] p2_x, p2_y, p3_x, p3_y;
	logic signed [Msb:0] a_x, a_y, b_x, b_y, c_x, c_y;
	logic signed [Msb:0] u1, u0, w1, w0;
	logic signed [DiffWidth-1:0] opa_n, opb_n;
	logic                meet_x, meet_y, bbox_q;

	logic                        valid_s1, valid_s2;
	logic [StepWidth-1:0]        step_s1, step_s2;
	logic signed [DiffWidth-1:0] opa_s1, opb_s1;
	logic signed [ProdWidth-1:0] prod_s2, prod0_q;
	logic [3:0]                  neg_q, zero_q;
	logic                        fail_edge, fail_move, touch;
	logic                        result_valid_q, crossed_q;

	// item and polygon registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ms_x_q  <= move_start_x[Msb:0];
			ms_y_q  <= move_start_y[Msb:0];
			me_x_q  <= move_end_x[Msb:0];
			me_y_q  <= move_end_y[Msb:0];
			v_x_q   <= vertex_x[Msb:0];
			v_y_q   <= vertex_y[Msb:0];
			solid_q <= wall_solid;
			first_q <= first_vertex;
			last_q  <= last_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vx_q   <= '0;
			first_vy_q   <= '0;
			prev_vx_q    <= '0;
			prev_vy_q    <= '0;
			prev_solid_q <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			if (cmd.load && first_vertex) begin
				first_vx_q <= vertex_x[Msb:0];
				first_vy_q <= vertex_y[Msb:0];
			end
			if (cmd.commit) begin
				prev_vx_q    <= v_x_q;
				prev_vy_q    <= v_y_q;
				prev_solid_q <= solid_q;
			end
			if (cmd.load && first_vertex) begin
				hit_q <= 1'b0;
			end else if (cmd.eval && touch) begin
				hit_q <= 1'b1;
			end else if (cmd.emit) begin
				hit_q <= 1'b0;
			end
		end
	end

	// edge under test: previous to current, or current back to first
	assign p2_x = cmd.close ? v_x_q : prev_vx_q;
	assign p2_y = cmd.close ? v_y_q : prev_vy_q;
	assign p3_x = cmd.close ? first_vx_q : v_x_q;
	assign p3_y = cmd.close ? first_vy_q : v_y_q;

	always_comb begin
		case (cmd.step[StepWidth-1:1])
			ORI_MOVE_EDGE_START: begin
				a_x = ms_x_q; a_y = ms_y_q; b_x = me_x_q; b_y = me_y_q; c_x = p2_x; c_y = p2_y;
			end
			ORI_MOVE_EDGE_END: begin
				a_x = ms_x_q; a_y = ms_y_q; b_x = me_x_q; b_y = me_y_q; c_x = p3_x; c_y = p3_y;
			end
			ORI_EDGE_MOVE_START: begin
				a_x = p2_x; a_y = p2_y; b_x = p3_x; b_y = p3_y; c_x = ms_x_q; c_y = ms_y_q;
			end
			ORI_EDGE_MOVE_END: begin
				a_x = p2_x; a_y = p2_y; b_x = p3_x; b_y = p3_y; c_x = me_x_q; c_y = me_y_q;
			end
			default: begin
				a_x = ms_x_q; a_y = ms_y_q; b_x = me_x_q; b_y = me_y_q; c_x = p2_x; c_y = p2_y;
			end
		endcase
	end

	// even step (bx-ax)*(cy-ay), odd step (by-ay)*(cx-ax)
	assign u1 = cmd.step[0] ? b_y : b_x;
	assign u0 = cmd.step[0] ? a_y : a_x;
	assign w1 = cmd.step[0] ? c_x : c_y;
	assign w0 = cmd.step[0] ? a_x : a_y;

	assign opa_n = $signed({u1[Msb], u1}) - $signed({u0[Msb], u0});
	assign opb_n = $signed({w1[Msb], w1}) - $signed({w0[Msb], w0});

	// bounding boxes meet when, on each axis, some end of each is at or below some end of the other
	assign meet_x = ((ms_x_q <= p2_x) || (ms_x_q <= p3_x) || (me_x_q <= p2_x) ||
			(me_x_q <= p3_x)) &&
			((p2_x <= ms_x_q) || (p2_x <= me_x_q) || (p3_x <= ms_x_q) ||
			(p3_x <= me_x_q));
	assign meet_y = ((ms_y_q <= p2_y) || (ms_y_q <= p3_y) || (me_y_q <= p2_y) ||
			(me_y_q <= p3_y)) &&
			((p2_y <= ms_y_q) || (p2_y <= me_y_q) || (p3_y <= ms_y_q) ||
			(p3_y <= me_y_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue && (cmd.step == '0)) begin
			bbox_q <= meet_x && meet_y;
		end
		step_s1 <= cmd.step;
		opa_s1  <= opa_n;
		opb_s1  <= opb_n;
		step_s2 <= step_s1;
		prod_s2 <= ProdWidth'(opa_s1) * ProdWidth'(opb_s1);
		if (valid_s2) begin
			if (!step_s2[0]) begin
				prod0_q <= prod_s2;
			end else begin
				neg_q[step_s2[StepWidth-1:1]]  <= (prod0_q < prod_s2);
				zero_q[step_s2[StepWidth-1:1]] <= (prod0_q == prod_s2);
			end
		end
	end

	// both ends strictly on the same side means no contact
	assign fail_edge = !zero_q[ORI_MOVE_EDGE_START] && !zero_q[ORI_MOVE_EDGE_END] &&
			(neg_q[ORI_MOVE_EDGE_START] == neg_q[ORI_MOVE_EDGE_END]);
	assign fail_move = !zero_q[ORI_EDGE_MOVE_START] && !zero_q[ORI_EDGE_MOVE_END] &&
			(neg_q[ORI_EDGE_MOVE_START] == neg_q[ORI_EDGE_MOVE_END]);
	assign touch = bbox_q && !fail_edge && !fail_move;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			crossed_q <= hit_q;
		end
	end

	assign crossed      = crossed_q;
	assign result_valid = result_valid_q;

	assign sts.need_reg   = !first_q && prev_solid_q;
	assign sts.need_close = last_q && solid_q;
	assign sts.is_last    = last_q;
	assign sts.out_busy   = result_valid_q && result_stall;

endmodule

[tb/ppwc_crossing_checker.sv]
// checker for the path polygon wall crossing block: watches both channels,
// predicts the crossed flag of each closed polygon and compares it
// depends on ppwc_pkg for the coordinate width
module ppwc_crossing_checker import ppwc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_valid,
	input  logic                         vertex_stall,
	input  logic signed [CoordWidth-1:0] move_start_x,
	input  logic signed [CoordWidth-1:0] move_start_y,
	input  logic signed [CoordWidth-1:0] move_end_x,
	input  logic signed [CoordWidth-1:0] move_end_y,
	input  logic signed [CoordWidth-1:0] vertex_x,
	input  logic signed [CoordWidth-1:0] vertex_y,
	input  logic                         wall_solid,
	input  logic                         first_vertex,
	input  logic                         last_vertex,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic                         crossed,
	output int                           fail_count,
	output int                           pending,
	output int                           results_seen,
	output int                           hits_seen
);

	typedef logic signed [CoordWidth-1:0]   coord_t;
	typedef logic signed [CoordWidth:0]     diff_t;
	typedef logic signed [2*CoordWidth+1:0] prod_t;

	// open polygon as the block should see it
	coord_t ring_first_x, ring_first_y;
	coord_t ring_prev_x, ring_prev_y;
	logic   ring_prev_solid;
	logic   ring_hit;
	logic   crossed_q[$];

	// sign of (b - a) x (c - a), exact
	function automatic int turn_sign(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy);
		diff_t ux, uy, wx, wy;
		prod_t lhs, rhs;
		ux = diff_t'(bx) - diff_t'(ax);
		uy = diff_t'(by) - diff_t'(ay);
		wx = diff_t'(cx) - diff_t'(ax);
		wy = diff_t'(cy) - diff_t'(ay);
		lhs = prod_t'(ux) * prod_t'(wy);
		rhs = prod_t'(uy) * prod_t'(wx);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	function automatic logic spans_meet(coord_t a, coord_t b, coord_t c, coord_t d);
		coord_t lo_ab, hi_ab, lo_cd, hi_cd;
		lo_ab = (a < b) ? a : b;
		hi_ab = (a < b) ? b : a;
		lo_cd = (c < d) ? c : d;
		hi_cd = (c < d) ? d : c;
		return ((lo_ab > lo_cd) ? lo_ab : lo_cd) <= ((hi_ab < hi_cd) ? hi_ab : hi_cd);
	endfunction

	// movement s->e against wall p->q, touching counts
	function automatic logic edge_touches(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			coord_t px, coord_t py, coord_t qx, coord_t qy);
		if (!spans_meet(sx, ex, px, qx) || !spans_meet(sy, ey, py, qy))
			return 1'b0;
		if (turn_sign(sx, sy, ex, ey, px, py) * turn_sign(sx, sy, ex, ey, qx, qy) > 0)
			return 1'b0;
		if (turn_sign(px, py, qx, qy, sx, sy) * turn_sign(px, py, qx, qy, ex, ey) > 0)
			return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic want;
		if (!arst_n) begin
			ring_first_x = '0;
			ring_first_y = '0;
			ring_prev_x = '0;
			ring_prev_y = '0;
			ring_prev_solid = 1'b0;
			ring_hit = 1'b0;
			crossed_q.delete();
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
			hits_seen <= 0;
		end else begin
			// results first: one taken at this edge belongs to an earlier item
			if (result_valid && !result_stall) begin
				if (crossed_q.size() == 0) begin
					$error("crossed: expected nothing, actual %0b", crossed);
					fail_count <= fail_count + 1;
				end else begin
					want = crossed_q.pop_front();
					if (crossed !== want) begin
						$error("crossed: expected %0b, actual %0b", want, crossed);
						fail_count <= fail_count + 1;
					end
				end
				results_seen <= results_seen + 1;
				hits_seen <= hits_seen + (crossed === 1'b1);
			end
			if (vertex_valid && !vertex_stall) begin
				if (first_vertex) begin
					ring_first_x = vertex_x;
					ring_first_y = vertex_y;
					ring_hit = 1'b0;
				end else if (ring_prev_solid && edge_touches(move_start_x, move_start_y,
						move_end_x, move_end_y, ring_prev_x, ring_prev_y,
						vertex_x, vertex_y)) begin
					ring_hit = 1'b1;
				end
				ring_prev_x = vertex_x;
				ring_prev_y = vertex_y;
				ring_prev_solid = wall_solid;
				if (last_vertex) begin
					if (wall_solid && edge_touches(move_start_x, move_start_y,
							move_end_x, move_end_y, vertex_x, vertex_y,
							ring_first_x, ring_first_y))
						ring_hit = 1'b1;
					crossed_q.push_back(ring_hit);
					ring_hit = 1'b0;
				end
			end
			pending <= crossed_q.size();
		end
	end

endmodule

[tb/tb_path_polygon_wall_crossing.sv]
// testbench top for the path polygon wall crossing block: clock, reset,
// vertex stimulus, result back-pressure and the verdict
// depends on ppwc_pkg, path_polygon_wall_crossing and ppwc_crossing_checker
module tb_path_polygon_wall_crossing;
	import ppwc_pkg::*;

	localparam int RandomItems   = 1450;
	localparam int TimeoutCycles = 400000;
	// longest item is two tested edges plus the emit cycle
	localparam int DrainCycles   = 30;

	typedef logic signed [CoordWidth-1:0] coord_t;

	localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};
	localparam coord_t CoordMax = ~CoordMin;

	typedef struct packed {
		coord_t sx, sy, ex, ey;
		coord_t vx, vy;
		logic   solid;
		logic   first;
		logic   last;
	} vertex_item_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   vertex_valid = 1'b0;
	logic   result_stall = 1'b0;
	coord_t move_start_x = '0;
	coord_t move_start_y = '0;
	coord_t move_end_x = '0;
	coord_t move_end_y = '0;
	coord_t vertex_x = '0;
	coord_t vertex_y = '0;
	logic   wall_solid = 1'b0;
	logic   first_vertex = 1'b0;
	logic   last_vertex = 1'b0;
	logic   vertex_stall;
	logic   result_valid;
	logic   crossed;

	int fail_count, pending, results_seen, hits_seen;
	int items_sent = 0;
	int cycle_count = 0;
	// idling odds in percent, changed between phases
	int send_gap_pct = 34;
	int recv_stall_pct = 57;

	path_polygon_wall_crossing u_top (.*);

	ppwc_crossing_checker u_checker (.*);

	always #5 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// whole units in Q16.16
	function automatic coord_t q16(int units);
		return coord_t'(units * 65536);
	endfunction

	// scale 0: tiny grid, full of collinear and touching cases
	// scale 1: around the origin, fractional bits set
	// scale 2: anywhere in the range
	// scale 3: range ends, values next to them, and -1, 0 and 1
	function automatic coord_t pick_coord(int scale);
		int r;
		case (scale)
			0: begin
				r = $urandom_range(6);
				return q16(r - 3);
			end
			1: return coord_t'($urandom_range(131072)) - coord_t'(65536);
			2: return coord_t'($urandom);
			default: begin
				case ($urandom_range(6))
					0: return CoordMin;
					1: return CoordMax;
					2: return CoordMin + 1;
					3: return CoordMax - 1;
					4: return coord_t'(-1);
					5: return coord_t'(1);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic vertex_item_t make_item(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			coord_t vx, coord_t vy, logic solid, logic first, logic last);
		vertex_item_t it;
		it.sx = sx;
		it.sy = sy;
		it.ex = ex;
		it.ey = ey;
		it.vx = vx;
		it.vy = vy;
		it.solid = solid;
		it.first = first;
		it.last = last;
		return it;
	endfunction

	// present one item and hold it until taken; valid stays high on return so
	// a back-to-back item needs no second assignment in the same step
	task automatic send_vertex(input vertex_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			vertex_valid <= 1'b0;
			@(posedge clk);
		end
		vertex_valid <= 1'b1;
		move_start_x <= it.sx;
		move_start_y <= it.sy;
		move_end_x <= it.ex;
		move_end_y <= it.ey;
		vertex_x <= it.vx;
		vertex_y <= it.vy;
		wall_solid <= it.solid;
		first_vertex <= it.first;
		last_vertex <= it.last;
		do
			@(posedge clk);
		while (vertex_stall !== 1'b0);
		items_sent++;
	endtask

	// drop valid and wait for every predicted result; the first edge lets
	// the checker's count catch up with the item just taken
	task automatic hold_until_drained();
		vertex_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one polygon with a fixed movement segment; now and then broken by a
	// missing first flag or left open so the next polygon restarts it
	task automatic send_polygon();
		int scale, count;
		logic keep_first, keep_last;
		coord_t sx, sy, ex, ey;
		scale = $urandom_range(3);
		count = ($urandom_range(99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 12);
		keep_first = 1'b1;
		keep_last = 1'b1;
		if ($urandom_range(99) < 15) begin
			if ($urandom_range(1))
				keep_first = 1'b0;
			else
				keep_last = 1'b0;
		end
		sx = pick_coord(scale);
		sy = pick_coord(scale);
		ex = pick_coord(scale);
		ey = pick_coord(scale);
		for (int i = 0; i < count; i++)
			send_vertex(make_item(sx, sy, ex, ey, pick_coord(scale), pick_coord(scale),
				$urandom_range(99) < 70, keep_first && i == 0,
				keep_last && i == count - 1));
	endtask

	// mostly polygons, the rest lone items with random flags and segment
	task automatic run_random(input int quota);
		int target, scale;
		target = items_sent + quota;
		while (items_sent < target) begin
			if ($urandom_range(99) < 10) begin
				scale = $urandom_range(3);
				send_vertex(make_item(pick_coord(scale), pick_coord(scale), pick_coord(scale),
					pick_coord(scale), pick_coord(scale), pick_coord(scale),
					1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			end else begin
				send_polygon();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first vertex straight after reset: closing edge runs to the origin
		send_vertex(make_item(q16(-1), q16(-1), q16(1), q16(1), q16(1), q16(-1), 1, 0, 1));
		// single-vertex polygons, point on the path and point beside it
		send_vertex(make_item(q16(-2), q16(0), q16(2), q16(0), q16(1), q16(0), 1, 1, 1));
		send_vertex(make_item(q16(-2), q16(0), q16(2), q16(0), q16(1), q16(1), 1, 1, 1));
		// solid square crossed by the path
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(-1), q16(-1), 1, 1, 0));
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(1), q16(-1), 1, 0, 0));
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(1), q16(1), 1, 0, 0));
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(-1), q16(1), 1, 0, 1));
		// solid square with the whole path inside
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(-4), q16(-4), 1, 1, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(4), q16(-4), 1, 0, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(4), q16(4), 1, 0, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(-4), q16(4), 1, 0, 1));
		// crossed triangle with no solid wall
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(-1), q16(-1), 0, 1, 0));
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(1), q16(-1), 0, 0, 0));
		send_vertex(make_item(q16(-3), q16(0), q16(3), q16(0), q16(0), q16(2), 0, 0, 1));
		// range ends everywhere: widest differences and products
		send_vertex(make_item(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
			1, 1, 0));
		send_vertex(make_item(CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, CoordMin,
			1, 0, 0));
		send_vertex(make_item(CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, CoordMax,
			1, 0, 1));
		// collinear wall, overlapping and then disjoint
		send_vertex(make_item(q16(2), q16(0), q16(6), q16(0), q16(0), q16(0), 1, 1, 0));
		send_vertex(make_item(q16(2), q16(0), q16(6), q16(0), q16(4), q16(0), 1, 0, 1));
		send_vertex(make_item(q16(5), q16(0), q16(6), q16(0), q16(0), q16(0), 1, 1, 0));
		send_vertex(make_item(q16(5), q16(0), q16(6), q16(0), q16(4), q16(0), 1, 0, 1));
		// hit in an open polygon, then a new first vertex must clear it
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(0), q16(-5), 1, 1, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(0), q16(5), 1, 0, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(10), q16(10), 0, 1, 0));
		send_vertex(make_item(q16(-1), q16(0), q16(1), q16(0), q16(11), q16(10), 0, 0, 1));

		// sender holds off until the block has answered everything so far
		hold_until_drained();

		// sender gaps lighter than receiver stalls, then the other way round,
		// then both sides flat out
		run_random(RandomItems / 3);
		send_gap_pct = 57;
		recv_stall_pct = 34;
		run_random(RandomItems / 3);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_random(RandomItems - 2 * (RandomItems / 3));

		hold_until_drained();
		// room for any stray result after the last expected one
		repeat (DrainCycles) @(posedge clk);

		$display("summary: %0d vertex items over three idling phases, %0d results (%0d hits)",
			items_sent, results_seen, hits_seen);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// a hung handshake ends the run here
	initial begin
		while (cycle_count < TimeoutCycles) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("tb: failure");
		$finish;
	end

endmodule
